/* src/mbrf_pkg.sv */
package mbrf_pkg;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned REG_IDX_W  = 2;

    localparam logic [7:0]  FUNCTION_CODE_RESET = 8'h01;
    localparam logic [15:0] START_ADDRESS_RESET = 16'h0000;
    localparam logic [15:0] QUANTITY_RESET      = 16'h0008;

    // CRC-16/MODBUS: polynomial 0x8005 applied bit-reversed (0xA001), LSB first.
    localparam logic [15:0] CRC_INIT           = 16'hFFFF;
    localparam logic [15:0] CRC_POLY_REFLECTED = 16'hA001;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_FUNCTION_CODE = 2'd0,
        REG_START_ADDRESS = 2'd1,
        REG_QUANTITY      = 2'd2
    } mbrf_reg_t;

    // Position of a byte within the request frame, in transmit order.
    typedef enum logic [2:0] {
        POS_ADDR     = 3'd0,
        POS_FUNC     = 3'd1,
        POS_START_HI = 3'd2,
        POS_START_LO = 3'd3,
        POS_QTY_HI   = 3'd4,
        POS_QTY_LO   = 3'd5,
        POS_CRC_LO   = 3'd6,
        POS_CRC_HI   = 3'd7
    } mbrf_pos_t;

    typedef struct packed {
        logic [7:0]  function_code;
        logic [15:0] start_address;
        logic [15:0] quantity;
    } mbrf_cfg_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] slave_address;
    } mbrf_head_t;

    function automatic logic [15:0] crc_add_byte(input logic [15:0] crc_in,
                                                 input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            if (crc[0])
                crc = (crc >> 1) ^ CRC_POLY_REFLECTED;
            else
                crc = crc >> 1;
        end
        return crc;
    endfunction

endpackage

/* src/mbrf_if.sv */
interface mbrf_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] slave_address;

    modport source (output valid, output slave_address, input ready);
    modport sink   (input valid, input slave_address, output ready);
endinterface

interface mbrf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;

    modport source (output valid, output frame_byte, output last_byte, input ready);
    modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

/* src/mbrf_front.sv */
module mbrf_front #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    mbrf_req_if.sink            req,
    input  logic                pop,
    output mbrf_pkg::mbrf_head_t head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [7:0]       mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             do_pop;

    assign req.ready = (count_reg != CNT_W'(DEPTH));
    assign push      = req.valid && req.ready;
    assign do_pop    = pop && (count_reg != '0);

    assign head.valid         = (count_reg != '0);
    assign head.slave_address = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + CNT_W'(push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= req.slave_address;
    end

endmodule

/* src/mbrf_back.sv */
module mbrf_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mbrf_pkg::mbrf_head_t head,
    input  mbrf_pkg::mbrf_cfg_t  cfg,
    output logic                 pop,
    mbrf_byte_if.source          rsp
);

    mbrf_pkg::mbrf_pos_t pos_reg, pos_next;
    logic [15:0]         crc_reg, crc_next;
    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_byte_reg, out_byte_next;
    logic                out_last_reg, out_last_next;
    logic                load;
    logic [7:0]          byte_sel;

    // A new beat enters the output register whenever it is empty or being drained.
    assign load = head.valid && (!out_valid_reg || rsp.ready);
    assign pop  = load && (pos_reg == mbrf_pkg::POS_CRC_HI);

    always_comb
    begin
        unique case (pos_reg)
            mbrf_pkg::POS_ADDR:     byte_sel = head.slave_address;
            mbrf_pkg::POS_FUNC:     byte_sel = cfg.function_code;
            mbrf_pkg::POS_START_HI: byte_sel = cfg.start_address[15:8];
            mbrf_pkg::POS_START_LO: byte_sel = cfg.start_address[7:0];
            mbrf_pkg::POS_QTY_HI:   byte_sel = cfg.quantity[15:8];
            mbrf_pkg::POS_QTY_LO:   byte_sel = cfg.quantity[7:0];
            mbrf_pkg::POS_CRC_LO:   byte_sel = crc_reg[7:0];
            mbrf_pkg::POS_CRC_HI:   byte_sel = crc_reg[15:8];
            default:                byte_sel = '0;
        endcase
    end

    always_comb
    begin
        pos_next       = pos_reg;
        crc_next       = crc_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = byte_sel;
            out_last_next  = (pos_reg == mbrf_pkg::POS_CRC_HI);
            pos_next       = mbrf_pkg::mbrf_pos_t'(pos_reg + 3'd1);
            if (pos_reg == mbrf_pkg::POS_CRC_HI)
                crc_next = mbrf_pkg::CRC_INIT;
            else if (pos_reg != mbrf_pkg::POS_CRC_LO)
                crc_next = mbrf_pkg::crc_add_byte(crc_reg, byte_sel);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= mbrf_pkg::POS_ADDR;
            crc_reg       <= mbrf_pkg::CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.frame_byte = out_byte_reg;
    assign rsp.last_byte  = out_last_reg;

    // A frame in progress keeps its request at the head of the queue.
    a_head_held: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg != mbrf_pkg::POS_ADDR |-> head.valid)
        else $error("frame in progress without a queued request");

    // Closing a frame restarts the sequence and the CRC.
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        load && pos_reg == mbrf_pkg::POS_CRC_HI |=>
            pos_reg == mbrf_pkg::POS_ADDR && crc_reg == mbrf_pkg::CRC_INIT)
        else $error("frame did not restart after CRC high byte");

    // Positions advance by exactly one per loaded beat.
    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> 3'(pos_reg) == 3'($past(pos_reg) + 3'd1))
        else $error("frame position skipped");

    // The last flag is only ever shown on a valid beat taken from the CRC high position.
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_last_reg == ($past(pos_reg) == mbrf_pkg::POS_CRC_HI))
        else $error("last flag on wrong frame byte");

endmodule

/* src/modbus_read_request_framer.sv */
// Channel   Dir  Payload                         Handshake
// req       in   slave_address[7:0]              valid/ready, beat on valid && ready
// rsp       out  frame_byte[7:0], last_byte      valid/ready, beat on valid && ready
// cfg       in   cfg_index[1:0], cfg_wdata[15:0] cfg_we, no back-pressure
//
// Each request yields eight response beats, one per cycle while rsp is ready; the
// single byte-wide output register holds one beat at a time.
// A request is registered in the queue, then its first byte in the output register;
// requests are taken while the queue has room, so the input runs ahead while the output is stalled.
// Reset clears the queue, the frame sequencer and the output valid, and loads the
// register reset values; there is no clearing pass.
module modbus_read_request_framer #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                                clk,
    input  logic                                rst_n,
    mbrf_req_if.sink                            req,
    mbrf_byte_if.source                         rsp,
    input  logic                                cfg_we,
    input  logic [mbrf_pkg::REG_IDX_W-1:0]      cfg_index,
    input  logic [mbrf_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    // Configuration registers. Software writes them only while the block is idle (the block does
    // not enforce this), as the back end reads them directly while building a frame.
    logic [7:0]  function_code_reg;
    logic [15:0] start_address_reg;
    logic [15:0] quantity_reg;

    mbrf_pkg::mbrf_cfg_t  cfg;
    mbrf_pkg::mbrf_head_t head;
    logic                 pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            function_code_reg <= mbrf_pkg::FUNCTION_CODE_RESET;
            start_address_reg <= mbrf_pkg::START_ADDRESS_RESET;
            quantity_reg      <= mbrf_pkg::QUANTITY_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mbrf_pkg::REG_FUNCTION_CODE: function_code_reg <= cfg_wdata[7:0];
                mbrf_pkg::REG_START_ADDRESS: start_address_reg <= cfg_wdata;
                mbrf_pkg::REG_QUANTITY:      quantity_reg      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg.function_code = function_code_reg;
    assign cfg.start_address = start_address_reg;
    assign cfg.quantity      = quantity_reg;

    // The front end queues slave addresses; the back end walks through the eight
    // frame positions of the request at the queue head, folding each of the first
    // six bytes into the CRC as it is sent, and pops the request on its last byte.
    mbrf_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .pop   (pop),
        .head  (head)
    );

    mbrf_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .cfg   (cfg),
        .pop   (pop),
        .rsp   (rsp)
    );

endmodule
